// ===== src/igss_pkg.sv =====
// shared types, constants and log2 helpers for the information gain split selector
package igss_pkg;

  localparam int unsigned NumAttr     = 16;
  localparam int unsigned AttrIdxW    = 4;
  localparam int unsigned CountW      = 13;
  localparam int unsigned CountLimit  = 4096;
  localparam int unsigned GainW       = 17;
  localparam int unsigned GainMax     = 65536;
  localparam int unsigned LgW         = 20;
  localparam int unsigned FW          = 34;
  localparam int unsigned SW          = 38;
  localparam int unsigned QDepth      = 2;

  localparam logic [1:0] RegMask  = 2'd0;
  localparam logic [1:0] RegInUse = 2'd1;

  typedef struct packed {
    logic [NumAttr-1:0] bits;
    logic               pos;
    logic               last;
  } word_t;

  typedef struct packed {
    logic [AttrIdxW-1:0] best_attribute;
    logic                split_found;
    logic [GainW-1:0]    best_gain;
    logic                plurality_positive;
    logic                labels_all_same;
  } result_t;

  function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] c);
    logic [CountW-1:0] r;
    r = c;
    if (c < CountLimit[CountW-1:0]) begin
      r = c + 1'b1;
    end
    return r;
  endfunction

  function automatic logic [3:0] msb_pos(input logic [CountW:0] x);
    logic [3:0] e;
    e = '0;
    for (int i = 0; i <= CountW; i++) begin
      if (x[i]) begin
        e = i[3:0];
      end
    end
    return e;
  endfunction

endpackage

// ===== src/igss_front.sv =====
// front end: accepts examples and queues them for the back end
module igss_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  igss_pkg::word_t in_word_i,
  output logic           q_valid_o,
  input  logic           q_ready_i,
  output igss_pkg::word_t q_word_o
);

  igss_pkg::word_t mem_q [igss_pkg::QDepth];
  logic            wp_q, rp_q, wp_d, rp_d;
  logic [1:0]      cnt_q, cnt_d;
  logic            push, pop;

  assign in_ready_o = cnt_q != 2'd2;
  assign q_valid_o  = cnt_q != 2'd0;
  assign q_word_o   = mem_q[rp_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_valid_o && q_ready_i;

  always_comb begin
    wp_d  = wp_q ^ push;
    rp_d  = rp_q ^ pop;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= in_word_i;
    end
  end

endmodule

// ===== src/igss_lg.sv =====
// multicycle x*log2(x) unit, one squaring per cycle
module igss_lg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [igss_pkg::CountW:0]       x_i,
  output logic                            done_o,
  output logic [igss_pkg::FW-1:0]         f_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StSq   = 2'd1;
  localparam logic [1:0] StMul  = 2'd2;

  logic [1:0]                  st_q, st_d;
  logic [4:0]                  k_q, k_d;
  logic [31:0]                 m_q, m_d;
  logic [igss_pkg::LgW-1:0]    r_q, r_d;
  logic [igss_pkg::CountW:0]   x_q, x_d;
  logic [igss_pkg::FW-1:0]     f_q, f_d;
  logic                        done_d, done_q;
  logic [63:0]                 sq;
  logic [3:0]                  e;

  assign e  = igss_pkg::msb_pos(x_i);
  assign sq = {32'd0, m_q} * {32'd0, m_q};

  always_comb begin
    st_d   = st_q;
    k_d    = k_q;
    m_d    = m_q;
    r_d    = r_q;
    x_d    = x_q;
    f_d    = f_q;
    done_d = 1'b0;
    unique case (st_q)
      StIdle: begin
        if (start_i) begin
          x_d  = x_i;
          m_d  = 32'({x_i, 30'd0} >> e);
          r_d  = {e, 16'd0};
          k_d  = 5'd16;
          st_d = (x_i == '0) ? StMul : StSq;
        end
      end
      StSq: begin
        m_d = sq[61:30];
        if (sq[61]) begin
          m_d = sq[62:31];
          r_d[k_q-5'd1] = 1'b1;
        end
        k_d = k_q - 5'd1;
        if (k_q == 5'd1) begin
          st_d = StMul;
        end
      end
      StMul: begin
        f_d    = (x_q == '0) ? '0
               : ({{(igss_pkg::FW-igss_pkg::CountW-1){1'b0}}, x_q}
                  * {{(igss_pkg::FW-igss_pkg::LgW){1'b0}}, r_q});
        done_d = 1'b1;
        st_d   = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= StIdle;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q <= k_d;
    m_q <= m_d;
    r_q <= r_d;
    x_q <= x_d;
    f_q <= f_d;
  end

  assign done_o = done_q;
  assign f_o    = f_q;

endmodule

// ===== src/igss_back.sv =====
// back end: counts examples, then evaluates gain per attribute
module igss_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              q_valid_i,
  output logic                              q_ready_o,
  input  igss_pkg::word_t                   q_word_i,
  input  logic [igss_pkg::NumAttr-1:0]      mask_i,
  input  logic [4:0]                        in_use_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output igss_pkg::result_t                 out_o
);

  localparam logic [3:0] StCount = 4'd0;
  localparam logic [3:0] StWhole = 4'd1;
  localparam logic [3:0] StAttr  = 4'd2;
  localparam logic [3:0] StLgGo  = 4'd3;
  localparam logic [3:0] StLgW   = 4'd4;
  localparam logic [3:0] StSum   = 4'd5;
  localparam logic [3:0] StDiv   = 4'd6;
  localparam logic [3:0] StCmp   = 4'd7;
  localparam logic [3:0] StOut   = 4'd8;

  localparam int unsigned CW = igss_pkg::CountW;

  logic [3:0]                st_q, st_d;
  logic [CW-1:0]             p1_q [igss_pkg::NumAttr];
  logic [CW-1:0]             n1_q [igss_pkg::NumAttr];
  logic [CW-1:0]             pt_q, nt_q;
  logic [4:0]                ai_q, ai_d;
  logic [4:0]                limit;
  logic [2:0]                ti_q, ti_d;
  logic [CW:0]               tv [6];
  logic signed [igss_pkg::SW-1:0] acc_q, acc_d;
  logic signed [igss_pkg::SW-1:0] whole_q, whole_d;
  logic [igss_pkg::SW-1:0]   num_q, num_d;
  logic [igss_pkg::GainW:0]  quo_q, quo_d;
  logic [5:0]                dc_q, dc_d;
  logic [igss_pkg::SW:0]     rem_q, rem_d;
  logic [igss_pkg::SW:0]     trial;
  logic                      found_q, found_d;
  logic [igss_pkg::AttrIdxW-1:0] bi_q, bi_d;
  logic [igss_pkg::GainW-1:0] bg_q, bg_d;
  logic                      phase_q, phase_d;
  logic                      lg_start, lg_done;
  logic [CW:0]               lg_x;
  logic [igss_pkg::FW-1:0]   lg_f;
  logic                      clear, count;
  logic [CW-1:0]             cp1, cn1, cp0, cn0;
  logic [CW:0]               tt;
  logic                      elig;

  assign limit = (in_use_i > 5'd16) ? 5'd16 : in_use_i;
  assign tt    = {1'b0, pt_q} + {1'b0, nt_q};
  assign cp1   = p1_q[ai_q[3:0]];
  assign cn1   = n1_q[ai_q[3:0]];
  assign cp0   = (pt_q >= cp1) ? pt_q - cp1 : '0;
  assign cn0   = (nt_q >= cn1) ? nt_q - cn1 : '0;
  assign elig  = mask_i[ai_q[3:0]] && (cp1 != '0 || cn1 != '0)
              && (cp0 != '0 || cn0 != '0) && tt != '0;

  always_comb begin
    if (phase_q) begin
      tv[0] = {1'b0, cp1} + {1'b0, cn1};
      tv[1] = {1'b0, cp1};
      tv[2] = {1'b0, cn1};
      tv[3] = {1'b0, cp0} + {1'b0, cn0};
      tv[4] = {1'b0, cp0};
      tv[5] = {1'b0, cn0};
    end else begin
      tv[0] = tt;
      tv[1] = {1'b0, pt_q};
      tv[2] = {1'b0, nt_q};
      tv[3] = '0;
      tv[4] = '0;
      tv[5] = '0;
    end
  end

  assign lg_x     = tv[ti_q];
  assign lg_start = st_q == StLgGo;
  assign count    = st_q == StCount && q_valid_i;
  assign clear    = st_q == StOut && out_ready_i;
  assign q_ready_o = st_q == StCount;
  assign trial    = {rem_q[igss_pkg::SW-1:0], num_q[igss_pkg::SW-1]}
                  - {{(igss_pkg::SW-CW){1'b0}}, tt};

  igss_lg u_lg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(lg_start),
    .x_i    (lg_x),
    .done_o (lg_done),
    .f_o    (lg_f)
  );

  always_comb begin
    st_d    = st_q;
    ai_d    = ai_q;
    ti_d    = ti_q;
    acc_d   = acc_q;
    whole_d = whole_q;
    num_d   = num_q;
    quo_d   = quo_q;
    dc_d    = dc_q;
    rem_d   = rem_q;
    found_d = found_q;
    bi_d    = bi_q;
    bg_d    = bg_q;
    phase_d = phase_q;
    unique case (st_q)
      StCount: begin
        if (count && q_word_i.last) begin
          phase_d = 1'b0;
          ti_d    = 3'd0;
          acc_d   = '0;
          found_d = 1'b0;
          bi_d    = '0;
          bg_d    = '0;
          st_d    = StLgGo;
        end
      end
      StLgGo: st_d = StLgW;
      StLgW: begin
        if (lg_done) begin
          if (ti_q == 3'd0 || ti_q == 3'd3) begin
            acc_d = acc_q + $signed({4'd0, lg_f});
          end else begin
            acc_d = acc_q - $signed({4'd0, lg_f});
          end
          if (!phase_q && ti_q == 3'd2) begin
            st_d = StWhole;
          end else if (phase_q && ti_q == 3'd5) begin
            st_d = StSum;
          end else begin
            ti_d = ti_q + 3'd1;
            st_d = StLgGo;
          end
        end
      end
      StWhole: begin
        whole_d = acc_q;
        phase_d = 1'b1;
        ai_d    = '0;
        st_d    = StAttr;
      end
      StAttr: begin
        if (ai_q >= limit) begin
          st_d = StOut;
        end else if (!elig) begin
          ai_d = ai_q + 5'd1;
        end else begin
          ti_d  = 3'd0;
          acc_d = '0;
          st_d  = StLgGo;
        end
      end
      StSum: begin
        acc_d = whole_q - acc_q;
        num_d = (acc_d < 0) ? igss_pkg::SW'({1'b0, tt[CW:1]})
                            : igss_pkg::SW'(acc_d) + igss_pkg::SW'({1'b0, tt[CW:1]});
        rem_d = '0;
        quo_d = '0;
        dc_d  = 6'(igss_pkg::SW);
        st_d  = StDiv;
      end
      StDiv: begin
        if (!trial[igss_pkg::SW]) begin
          rem_d = trial;
          quo_d = {quo_q[igss_pkg::GainW-1:0], 1'b1} | {quo_q[igss_pkg::GainW], {igss_pkg::GainW{1'b0}}}
                | ((quo_q[igss_pkg::GainW] || quo_q[igss_pkg::GainW-1]) ? {1'b1, {igss_pkg::GainW{1'b0}}} : '0);
        end else begin
          rem_d = {rem_q[igss_pkg::SW-1:0], num_q[igss_pkg::SW-1]};
          quo_d = {quo_q[igss_pkg::GainW-1:0], 1'b0}
                | ((quo_q[igss_pkg::GainW] || quo_q[igss_pkg::GainW-1]) ? {1'b1, {igss_pkg::GainW{1'b0}}} : '0);
        end
        num_d = {num_q[igss_pkg::SW-2:0], 1'b0};
        dc_d  = dc_q - 6'd1;
        if (dc_q == 6'd1) begin
          st_d = StCmp;
        end
      end
      StCmp: begin
        if (quo_q[igss_pkg::GainW] || quo_q[igss_pkg::GainW-1:0] > igss_pkg::GainMax) begin
          quo_d = (igss_pkg::GainW+1)'(igss_pkg::GainMax);
        end
        if (!found_q || quo_d[igss_pkg::GainW-1:0] > bg_q) begin
          found_d = 1'b1;
          bg_d    = quo_d[igss_pkg::GainW-1:0];
          bi_d    = ai_q[3:0];
        end
        ai_d = ai_q + 5'd1;
        st_d = StAttr;
      end
      StOut: begin
        if (out_ready_i) begin
          st_d = StCount;
        end
      end
      default: st_d = StCount;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StCount;
      pt_q <= '0;
      nt_q <= '0;
      for (int i = 0; i < igss_pkg::NumAttr; i++) begin
        p1_q[i] <= '0;
        n1_q[i] <= '0;
      end
    end else begin
      st_q <= st_d;
      if (clear) begin
        pt_q <= '0;
        nt_q <= '0;
        for (int i = 0; i < igss_pkg::NumAttr; i++) begin
          p1_q[i] <= '0;
          n1_q[i] <= '0;
        end
      end else if (count) begin
        if (q_word_i.pos) begin
          pt_q <= igss_pkg::sat_inc(pt_q);
        end else begin
          nt_q <= igss_pkg::sat_inc(nt_q);
        end
        for (int i = 0; i < igss_pkg::NumAttr; i++) begin
          if (q_word_i.bits[i]) begin
            if (q_word_i.pos) begin
              p1_q[i] <= igss_pkg::sat_inc(p1_q[i]);
            end else begin
              n1_q[i] <= igss_pkg::sat_inc(n1_q[i]);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ai_q    <= ai_d;
    ti_q    <= ti_d;
    acc_q   <= acc_d;
    whole_q <= whole_d;
    num_q   <= num_d;
    quo_q   <= quo_d;
    dc_q    <= dc_d;
    rem_q   <= rem_d;
    found_q <= found_d;
    bi_q    <= bi_d;
    bg_q    <= bg_d;
    phase_q <= phase_d;
  end

  assign out_valid_o                = st_q == StOut;
  assign out_o.best_attribute       = found_q ? bi_q : '0;
  assign out_o.split_found          = found_q;
  assign out_o.best_gain            = found_q ? bg_q : '0;
  assign out_o.plurality_positive   = pt_q >= nt_q;
  assign out_o.labels_all_same      = pt_q == '0 || nt_q == '0;

endmodule

// ===== src/info_gain_split_selector.sv =====
// top level of the information gain split selector
// Examples are accepted one per cycle into a two-word queue while it has room, and are
// counted at one per cycle while the back end is counting. After an example marked last,
// the block evaluates the whole set and then each enabled, eligible attribute with a
// shared iterative x*log2(x) unit (per term: start, 16 squarings, multiply, done; three
// terms for the set and six per attribute) followed by a bit-serial divide, before the
// result word shows. Counting resumes once the result word has been taken; examples keep
// queueing meanwhile until the queue fills.
module info_gain_split_selector (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] attribute_bits_i,
  input  logic        label_positive_i,
  input  logic        last_example_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  best_attribute_o,
  output logic        split_found_o,
  output logic [16:0] best_gain_o,
  output logic        plurality_positive_o,
  output logic        labels_all_same_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  igss_pkg::word_t   in_word, q_word;
  igss_pkg::result_t res;
  logic              q_valid, q_ready;
  logic [15:0]       mask_q;
  logic [4:0]        in_use_q;
  logic              wr;

  assign in_word = '{bits: attribute_bits_i, pos: label_positive_i, last: last_example_i};
  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q   <= 16'hFFFF;
      in_use_q <= 5'd16;
    end else if (wr) begin
      unique case (paddr[2])
        igss_pkg::RegMask[0]:  mask_q   <= pwdata[15:0];
        igss_pkg::RegInUse[0]: in_use_q <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      igss_pkg::RegMask[0]:  prdata = {16'd0, mask_q};
      igss_pkg::RegInUse[0]: prdata = {27'd0, in_use_q};
      default:               prdata = '0;
    endcase
  end

  igss_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_word_i (in_word),
    .q_valid_o (q_valid),
    .q_ready_i (q_ready),
    .q_word_o  (q_word)
  );

  igss_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_ready_o  (q_ready),
    .q_word_i   (q_word),
    .mask_i     (mask_q),
    .in_use_i   (in_use_q),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (res)
  );

  assign best_attribute_o     = res.best_attribute;
  assign split_found_o        = res.split_found;
  assign best_gain_o          = res.best_gain;
  assign plurality_positive_o = res.plurality_positive;
  assign labels_all_same_o    = res.labels_all_same;

endmodule

// ===== src/igss_checker.sv =====
// port-level checks for the information gain split selector
module igss_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [3:0]  best_attribute_o,
  input logic        split_found_o,
  input logic [16:0] best_gain_o,
  input logic        pready
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(best_gain_o))
    else $error("result dropped while stalled");

  a_nosplit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !split_found_o |-> best_gain_o == 17'd0 && best_attribute_o == 4'd0)
    else $error("no split but nonzero fields");

  a_gain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> best_gain_o <= 17'd65536)
    else $error("gain out of range");

  a_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i |=> !out_valid_o)
    else $error("result repeated");

  a_pready: assert property (@(posedge clk_i) pready)
    else $error("pready low");

endmodule

bind info_gain_split_selector igss_checker u_igss_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .best_attribute_o(best_attribute_o),
  .split_found_o   (split_found_o),
  .best_gain_o     (best_gain_o),
  .pready          (pready)
);
